@@ hw/rtl/tpcfg_pkg.sv @@
// ----------------------------------------------------------------------------
// tpcfg_pkg
// Types, frame constants and the byte selection function shared by the
// timepulse configuration frame builder and its checksum stage.
// ----------------------------------------------------------------------------
package tpcfg_pkg;

  localparam int FRAME_LEN = 40;
  localparam int POS_W     = 6;

  localparam logic [7:0] SYNC_1      = 8'hB5;
  localparam logic [7:0] SYNC_2      = 8'h62;
  localparam logic [7:0] MSG_CLASS   = 8'h06;
  localparam logic [7:0] MSG_ID      = 8'h31;
  localparam logic [7:0] LEN_LO      = 8'h20;
  localparam logic [7:0] LEN_HI      = 8'h00;

  localparam logic [POS_W-1:0] CK_FIRST = POS_W'(2);
  localparam logic [POS_W-1:0] CK_A_POS = POS_W'(38);
  localparam logic [POS_W-1:0] CK_B_POS = POS_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic               pulse_select;
    logic [7:0]         reserved_byte;
    logic signed [15:0] antenna_delay_ns;
    logic signed [15:0] rf_delay_ns;
    logic [31:0]        period_unlocked;
    logic [31:0]        period_locked;
    logic [31:0]        length_unlocked;
    logic [31:0]        length_locked;
    logic signed [31:0] user_delay_ns;
    logic [31:0]        mode_flags;
  } settings_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [POS_W-1:0] byte_position;
    logic             last_byte;
  } result_t;

  // One frame byte travelling between the selection and checksum stages.
  typedef struct packed {
    logic             valid;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
  } beat_t;

  // Byte of the frame at a given position; the checksum positions read as
  // zero here and are filled in by the checksum stage.
  function automatic logic [7:0] frame_byte_at(input settings_t s,
                                               input logic [POS_W-1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    unique case (pos)
      6'd0:  b = SYNC_1;
      6'd1:  b = SYNC_2;
      6'd2:  b = MSG_CLASS;
      6'd3:  b = MSG_ID;
      6'd4:  b = LEN_LO;
      6'd5:  b = LEN_HI;
      6'd6:  b = {7'b0, s.pulse_select};
      6'd7:  b = s.reserved_byte;
      6'd10: b = s.antenna_delay_ns[7:0];
      6'd11: b = s.antenna_delay_ns[15:8];
      6'd12: b = s.rf_delay_ns[7:0];
      6'd13: b = s.rf_delay_ns[15:8];
      6'd14: b = s.period_unlocked[7:0];
      6'd15: b = s.period_unlocked[15:8];
      6'd16: b = s.period_unlocked[23:16];
      6'd17: b = s.period_unlocked[31:24];
      6'd18: b = s.period_locked[7:0];
      6'd19: b = s.period_locked[15:8];
      6'd20: b = s.period_locked[23:16];
      6'd21: b = s.period_locked[31:24];
      6'd22: b = s.length_unlocked[7:0];
      6'd23: b = s.length_unlocked[15:8];
      6'd24: b = s.length_unlocked[23:16];
      6'd25: b = s.length_unlocked[31:24];
      6'd26: b = s.length_locked[7:0];
      6'd27: b = s.length_locked[15:8];
      6'd28: b = s.length_locked[23:16];
      6'd29: b = s.length_locked[31:24];
      6'd30: b = s.user_delay_ns[7:0];
      6'd31: b = s.user_delay_ns[15:8];
      6'd32: b = s.user_delay_ns[23:16];
      6'd33: b = s.user_delay_ns[31:24];
      6'd34: b = s.mode_flags[7:0];
      6'd35: b = s.mode_flags[15:8];
      6'd36: b = s.mode_flags[23:16];
      6'd37: b = s.mode_flags[31:24];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/tpcfg_checksum.sv @@
// ----------------------------------------------------------------------------
// tpcfg_checksum
// Running Fletcher sums over the frame bytes and the registered result beat.
// ----------------------------------------------------------------------------
module tpcfg_checksum (
  input  logic               clk,
  input  logic               rst,
  input  tpcfg_pkg::beat_t   beat_in,
  output logic               strobe,
  output tpcfg_pkg::result_t result
);

  tpcfg_pkg::beat_t beat_b;
  logic [7:0]       ck_a;
  logic [7:0]       ck_b;
  logic [7:0]       ck_a_next;
  logic [7:0]       ck_b_next;
  logic [7:0]       data_next;
  logic             in_range;

  // Sums restart on the sync bytes and cover the class byte up to the last
  // payload byte.
  always_comb begin
    in_range  = (beat_in.pos >= tpcfg_pkg::CK_FIRST) && (beat_in.pos < tpcfg_pkg::CK_A_POS);
    ck_a_next = ck_a;
    ck_b_next = ck_b;
    data_next = beat_in.data;
    if (beat_in.pos < tpcfg_pkg::CK_FIRST) begin
      ck_a_next = 8'h00;
      ck_b_next = 8'h00;
    end else if (in_range) begin
      ck_a_next = ck_a + beat_in.data;
      ck_b_next = ck_b + ck_a_next;
    end
    if (beat_in.pos == tpcfg_pkg::CK_A_POS) begin
      data_next = ck_a;
    end else if (beat_in.pos == tpcfg_pkg::CK_B_POS) begin
      data_next = ck_b;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_in.valid) begin
      ck_a <= ck_a_next;
      ck_b <= ck_b_next;
    end
    beat_b.data <= data_next;
    beat_b.pos  <= beat_in.pos;
    result.frame_byte    <= beat_b.data;
    result.byte_position <= beat_b.pos;
    result.last_byte     <= (beat_b.pos == tpcfg_pkg::CK_B_POS);
    if (rst) begin
      beat_b.valid <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      beat_b.valid <= beat_in.valid;
      strobe       <= beat_b.valid;
    end
  end

endmodule

@@ hw/rtl/timepulse_config_frame_builder.sv @@
// ----------------------------------------------------------------------------
// timepulse_config_frame_builder
// Turns one set of timepulse settings into a 40-byte configuration frame
// with sync, header, little-endian payload and Fletcher checksum.
// ----------------------------------------------------------------------------
// Usage. A settings beat is presented on settings with start high; it is
// taken at the rising edge where start is high and busy is low. The block
// answers with 40 result beats, one per cycle, each marked by strobe for a
// single cycle and carrying the frame byte, its position 0 to 39 and a flag
// on the second checksum byte.
// The settings of a frame pass from the holding register into the
// serialiser and then through the register stages below before its first
// byte is strobed, provided no earlier frame is still going out. Frames
// follow each other on the byte-wide result channel with no gap. A holding
// register takes the next settings beat while the current frame is
// serialised, and busy is high only while that holding register is occupied.
// The frame moves through three register stages: byte selection from the
// frame counter, checksum accumulation, and the output register.
// Reset clears the holding register, the serialiser and every valid flag;
// no strobe is issued until new settings arrive. The receiver cannot stall
// the result channel, so no result is ever held back.
// ----------------------------------------------------------------------------
module timepulse_config_frame_builder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tpcfg_pkg::settings_t settings,
  output logic                 strobe,
  output tpcfg_pkg::result_t   result
);

  // Holding register for the next settings beat.
  tpcfg_pkg::settings_t pend;
  logic                 pend_valid;

  // Settings of the frame being serialised and its byte counter.
  tpcfg_pkg::settings_t cur;
  logic                 cur_active;
  logic [tpcfg_pkg::POS_W-1:0] cnt;

  // First pipeline stage: the selected byte and its position.
  tpcfg_pkg::beat_t beat_a;

  logic accept;
  logic cur_done;

  assign busy     = pend_valid;
  assign accept   = start && !pend_valid;
  // The serialiser is free for new settings when idle or on its last byte.
  assign cur_done = !cur_active || (cnt == tpcfg_pkg::CK_B_POS);

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= settings;
    end
    if (cur_done && pend_valid) begin
      cur <= pend;
    end
    beat_a.data <= tpcfg_pkg::frame_byte_at(cur, cnt);
    beat_a.pos  <= cnt;
    if (rst) begin
      pend_valid   <= 1'b0;
      cur_active   <= 1'b0;
      cnt          <= '0;
      beat_a.valid <= 1'b0;
    end else begin
      beat_a.valid <= cur_active;
      // A move out of the holding register and a new accept never coincide,
      // since accept needs the holding register empty.
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (cur_done && pend_valid) begin
        pend_valid <= 1'b0;
      end
      if (!cur_done) begin
        cnt <= cnt + 1'b1;
      end else if (pend_valid) begin
        cnt        <= '0;
        cur_active <= 1'b1;
      end else begin
        cnt        <= '0;
        cur_active <= 1'b0;
      end
    end
  end

  tpcfg_checksum u_checksum (
    .clk     (clk),
    .rst     (rst),
    .beat_in (beat_a),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

@@ tb/timepulse_config_frame_builder_tb.sv @@
// ----------------------------------------------------------------------------
// timepulse_config_frame_builder_tb
// Self-checking bench for the timepulse configuration frame builder. Settings
// beats are driven through the start/busy handshake and every strobed frame
// byte is compared against a frame computed inside the bench.
// ----------------------------------------------------------------------------
module timepulse_config_frame_builder_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // A quiet stretch is a cycle in which no settings beat is taken and no
  // frame byte is strobed. The longest legitimate one is a drain tail plus a
  // capped sender gap plus the pipeline latency, so this limit is generous.
  localparam int WATCHDOG_LIMIT = 400;
  localparam int MAX_GAP        = 30;
  localparam int DRAIN_TAIL     = 12;

  // --------------------------------------------------------------------------
  // Frame prediction and checking.
  // --------------------------------------------------------------------------
  class frame_byte_checker;
    tpcfg_pkg::result_t expected_bytes[$];
    int unsigned        settings_taken;
    int unsigned        bytes_checked;
    int unsigned        mismatches;

    function new();
      settings_taken = 0;
      bytes_checked  = 0;
      mismatches     = 0;
    endfunction

    // Builds the whole 40-byte frame for one settings beat, including the
    // Fletcher sums, and queues one expected result per byte.
    function void note_settings(input tpcfg_pkg::settings_t s);
      logic [7:0]         fb [tpcfg_pkg::FRAME_LEN];
      logic [15:0]        halves [2];
      logic [31:0]        words [6];
      logic [7:0]         sum_a;
      logic [7:0]         sum_b;
      tpcfg_pkg::result_t r;
      fb[0] = tpcfg_pkg::SYNC_1;
      fb[1] = tpcfg_pkg::SYNC_2;
      fb[2] = tpcfg_pkg::MSG_CLASS;
      fb[3] = tpcfg_pkg::MSG_ID;
      fb[4] = tpcfg_pkg::LEN_LO;
      fb[5] = tpcfg_pkg::LEN_HI;
      fb[6] = {7'b0, s.pulse_select};
      fb[7] = s.reserved_byte;
      // The reserved pair after the pass-through byte is always zero.
      fb[8] = 8'h00;
      fb[9] = 8'h00;
      halves[0] = s.antenna_delay_ns;
      halves[1] = s.rf_delay_ns;
      words[0]  = s.period_unlocked;
      words[1]  = s.period_locked;
      words[2]  = s.length_unlocked;
      words[3]  = s.length_locked;
      words[4]  = s.user_delay_ns;
      words[5]  = s.mode_flags;
      for (int h = 0; h < 2; h++) begin
        for (int k = 0; k < 2; k++) fb[10 + 2*h + k] = halves[h][8*k +: 8];
      end
      for (int w = 0; w < 6; w++) begin
        for (int k = 0; k < 4; k++) fb[14 + 4*w + k] = words[w][8*k +: 8];
      end
      sum_a = 8'h00;
      sum_b = 8'h00;
      for (int i = int'(tpcfg_pkg::CK_FIRST); i < int'(tpcfg_pkg::CK_A_POS); i++) begin
        sum_a = sum_a + fb[i];
        sum_b = sum_b + sum_a;
      end
      fb[tpcfg_pkg::CK_A_POS] = sum_a;
      fb[tpcfg_pkg::CK_B_POS] = sum_b;
      for (int i = 0; i < tpcfg_pkg::FRAME_LEN; i++) begin
        r.frame_byte    = fb[i];
        r.byte_position = tpcfg_pkg::POS_W'(i);
        r.last_byte     = (i == tpcfg_pkg::FRAME_LEN - 1);
        expected_bytes.push_back(r);
      end
      settings_taken++;
    endfunction

    function void check_byte(input tpcfg_pkg::result_t got);
      tpcfg_pkg::result_t want;
      if (expected_bytes.size() == 0) begin
        $error("frame byte %0h at position %0d strobed with nothing outstanding",
               got.frame_byte, got.byte_position);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.frame_byte !== want.frame_byte) begin
        $error("frame_byte: expected %0h, actual %0h (position %0d)",
               want.frame_byte, got.frame_byte, want.byte_position);
        mismatches++;
      end
      if (got.byte_position !== want.byte_position) begin
        $error("byte_position: expected %0d, actual %0d",
               want.byte_position, got.byte_position);
        mismatches++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %0b, actual %0b (position %0d)",
               want.last_byte, got.last_byte, want.byte_position);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  tpcfg_pkg::settings_t settings;
  logic                 strobe;
  tpcfg_pkg::result_t   result;

  frame_byte_checker checker_h = new();
  int unsigned       quiet_cycles;

  timepulse_config_frame_builder DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .settings (settings),
    .strobe   (strobe),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block's own
  // registers update, so a beat counts as taken when start was high and busy
  // was low during the cycle that this edge ends. The same applies to the
  // strobed result: it belongs to the cycle that has just finished.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) checker_h.note_settings(settings);
      if (strobe) checker_h.check_byte(result);
      if ((start && !busy) || strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Mostly uniform random bits, with a fair share of the field's edge values:
  // zero, all ones, and the two's complement minimum and maximum.
  function automatic logic [31:0] pick_bits(input int unsigned width);
    logic [31:0] mask;
    logic [31:0] top;
    mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'h1 << width) - 32'h1);
    top  = 32'h1 << (width - 1);
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return mask;
      2:       return top;
      3:       return top - 32'h1;
      default: return $urandom() & mask;
    endcase
  endfunction

  function automatic tpcfg_pkg::settings_t random_settings();
    tpcfg_pkg::settings_t s;
    s.pulse_select     = 1'(pick_bits(1));
    s.reserved_byte    = 8'(pick_bits(8));
    s.antenna_delay_ns = 16'(pick_bits(16));
    s.rf_delay_ns      = 16'(pick_bits(16));
    s.period_unlocked  = pick_bits(32);
    s.period_locked    = pick_bits(32);
    s.length_unlocked  = pick_bits(32);
    s.length_locked    = pick_bits(32);
    s.user_delay_ns    = pick_bits(32);
    s.mode_flags       = pick_bits(32);
    return s;
  endfunction

  // Presents one settings beat and holds it until the block takes it. Before
  // that, the sender may sit idle for a random number of cycles, with junk on
  // the settings bus so that nothing relies on it being stable while start is
  // low. Every change happens at the falling edge, and start is written once
  // per falling edge at most, so back-to-back beats keep it high throughout.
  task automatic send_beat(input tpcfg_pkg::settings_t s, input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start    <= 1'b0;
      settings <= random_settings();
      gap++;
    end
    @(negedge clk);
    start    <= 1'b1;
    settings <= s;
    do @(posedge clk); while (busy);
  endtask

  // Stops sending and waits until every byte of every accepted frame has been
  // strobed, then lets the pipeline settle.
  task automatic drain_frames();
    @(negedge clk);
    start <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned count, input int unsigned idle_pct);
    for (int unsigned n = 0; n < count; n++) send_beat(random_settings(), idle_pct);
  endtask

  // Hand-picked settings at full rate, so that the holding register is also
  // exercised from the first frame onwards.
  task automatic send_directed();
    tpcfg_pkg::settings_t s;
    // Everything zero: the frame is header, zeros and a header-only checksum.
    s = '0;
    send_beat(s, 0);
    // Everything ones: maximal checksum wrap-around; the reserved pair must
    // still come out as zero.
    s = '1;
    send_beat(s, 0);
    // Signed minima on the delay fields.
    s = '0;
    s.antenna_delay_ns = 16'sh8000;
    s.rf_delay_ns      = 16'sh8000;
    s.user_delay_ns    = 32'sh8000_0000;
    send_beat(s, 0);
    // Signed maxima with the 32-bit unsigned fields at their top value.
    s = '0;
    s.antenna_delay_ns = 16'sh7FFF;
    s.rf_delay_ns      = 16'sh7FFF;
    s.user_delay_ns    = 32'sh7FFF_FFFF;
    s.period_unlocked  = 32'hFFFF_FFFF;
    s.period_locked    = 32'hFFFF_FFFF;
    s.length_unlocked  = 32'hFFFF_FFFF;
    s.length_locked    = 32'hFFFF_FFFF;
    s.mode_flags       = 32'hFFFF_FFFF;
    send_beat(s, 0);
    // Second timepulse output selected, nothing else set.
    s = '0;
    s.pulse_select = 1'b1;
    send_beat(s, 0);
    // Pass-through byte on its own.
    s = '0;
    s.reserved_byte = 8'hA5;
    send_beat(s, 0);
    // Each payload byte bar the select byte and the reserved pair equals its
    // frame position, showing up any byte swapped or field at a wrong offset.
    s.pulse_select     = 1'b0;
    s.reserved_byte    = 8'h07;
    s.antenna_delay_ns = 16'h0B0A;
    s.rf_delay_ns      = 16'h0D0C;
    s.period_unlocked  = 32'h1110_0F0E;
    s.period_locked    = 32'h1514_1312;
    s.length_unlocked  = 32'h1918_1716;
    s.length_locked    = 32'h1D1C_1B1A;
    s.user_delay_ns    = 32'h2120_1F1E;
    s.mode_flags       = 32'h2524_2322;
    send_beat(s, 0);
    // Alternating bit patterns, both phases.
    s = {1'b1, {29{8'h55}}};
    send_beat(s, 0);
    s = {1'b0, {29{8'hAA}}};
    send_beat(s, 0);
    send_random(4, 0);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. There are no configuration registers, so the run is one
  // long stream split into idling phases: flat out, a sender idle in just
  // over half its cycles, and a lightly idling sender. The block's receiver
  // side cannot be stalled, so only the sender varies. Drain pauses between
  // and within phases let the block run completely dry before new work.
  // --------------------------------------------------------------------------
  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    settings = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_directed();
    drain_frames();

    send_random(150, 0);
    drain_frames();

    send_random(75, 56);
    drain_frames();
    send_random(75, 56);
    drain_frames();

    send_random(130, 15);

    // Final drain; the watchdog bounds it if the block stops producing.
    drain_frames();

    $display("Ran %0d settings beats and checked %0d frame bytes,",
             checker_h.settings_taken, checker_h.bytes_checked);
    $display("with back-to-back, sparse and lightly gapped senders and drain pauses.");
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ timepulse_config_frame_builder.f @@
hw/rtl/tpcfg_pkg.sv
hw/rtl/tpcfg_checksum.sv
hw/rtl/timepulse_config_frame_builder.sv
tb/timepulse_config_frame_builder_tb.sv
